// ===== design/kpsdr_pkg.sv =====
// ----------------------------------------------------------------------------
// kpsdr_pkg
// Shared constants, codes and types for the keypad scan/debounce/repeat block.
// ----------------------------------------------------------------------------
package kpsdr_pkg;

    localparam int ROWS       = 4;
    localparam int COLS       = 4;
    localparam int TIMER_BITS = 16;

    localparam int MATRIX_W   = 16;
    localparam int CODE_W     = 8;
    localparam int TABLE_W    = 64;
    localparam int CFG_W      = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int SCAN_ROWS  = (ROWS < 4) ? ROWS : 4;
    localparam int SCAN_KEYS  = SCAN_ROWS * COLS;
    localparam int KEY_IDX_W  = $clog2(MATRIX_W);
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [CFG_ADDR_W-1:0] REG_TABLE_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TABLE_HIGH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT     = 3'd4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] FIRST_RST    = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd100;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DEBOUNCE = 3'd1;
    localparam logic [2:0] PH_PRESS    = 3'd2;
    localparam logic [2:0] PH_FIRST    = 3'd3;
    localparam logic [2:0] PH_REPEAT   = 3'd4;

    typedef logic [2*TABLE_W-1:0] t_table;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] first_delay_ticks;
        logic [CFG_W-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              is_repeat;
    } t_result;

endpackage

// ===== design/keypad_scan_debounce_repeat.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debounce_repeat
// 4x4 keypad qualifier with debounce and auto-repeat.
// ----------------------------------------------------------------------------
// Slave stream: one beat per tick (tuser = 0) or per scan (tuser = 1, tdata =
// active-low key snapshot). Master stream: one beat per scan, tdata = key
// code (0 for none), tuser = repeat flag. Ticks produce no output beat.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr;
// write only while no beats are in flight.
// Path: an accepted scan passes two stages, the input register, then the
// result register; a master stall can hold it in the input register.
// Throughput: one beat per cycle, but a scan waits while the master stalls.
// Reset (synchronous, active low): state idle, timer stopped, table zero,
// thresholds 20 / 500 / 100, both registers empty.
// Master stall: the result register holds; a tick in the input register still
// advances, a scan waits, and the slave side keeps taking beats while the
// input register is free or advancing.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_repeat
    import kpsdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [MATRIX_W-1:0]   i_s_axis_tdata,   // [15:0] key_matrix
    input  logic [0:0]            i_s_axis_tuser,   // [0] kind
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [CODE_W-1:0]     o_m_axis_tdata,   // [7:0] key_code
    output logic [0:0]            o_m_axis_tuser,   // [0] is_repeat
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_in_valid;
    logic                r_in_kind;
    logic [MATRIX_W-1:0] r_in_matrix;
    logic                r_out_valid;
    t_result             r_out;

    t_table            table_bits;
    t_cfg              cfg;
    logic [CODE_W-1:0] scan_code;
    t_result           result;
    logic              out_free;
    logic              step;

    kpsdr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_table    (table_bits),
        .o_cfg      (cfg)
    );

    kpsdr_scan u_scan (
        .i_matrix (r_in_matrix),
        .i_table  (table_bits),
        .o_code   (scan_code)
    );

    kpsdr_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_kind   (r_in_kind),
        .i_code   (scan_code),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && (r_in_kind == KIND_TICK || out_free);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_kind   <= i_s_axis_tuser[0];
            r_in_matrix <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && (r_in_kind == KIND_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && step && r_in_kind == KIND_SCAN) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out.key_code;
    assign o_m_axis_tuser[0] = r_out.is_repeat;

endmodule

// ===== design/kpsdr_cfg.sv =====
// ----------------------------------------------------------------------------
// kpsdr_cfg
// Configuration register file: code table and tick thresholds.
// ----------------------------------------------------------------------------
module kpsdr_cfg
    import kpsdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_table                o_table,
    output t_cfg                  o_cfg
);

    logic [TABLE_W-1:0] r_table_low;
    logic [TABLE_W-1:0] r_table_high;
    t_cfg               r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_low             <= '0;
            r_table_high            <= '0;
            r_cfg.debounce_ticks    <= DEBOUNCE_RST;
            r_cfg.first_delay_ticks <= FIRST_RST;
            r_cfg.repeat_ticks      <= REPEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TABLE_LOW:  r_table_low             <= i_cfg_data[TABLE_W-1:0];
                REG_TABLE_HIGH: r_table_high            <= i_cfg_data[TABLE_W-1:0];
                REG_DEBOUNCE:   r_cfg.debounce_ticks    <= i_cfg_data[CFG_W-1:0];
                REG_FIRST:      r_cfg.first_delay_ticks <= i_cfg_data[CFG_W-1:0];
                REG_REPEAT:     r_cfg.repeat_ticks      <= i_cfg_data[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_table = {r_table_high, r_table_low};
    assign o_cfg   = r_cfg;

endmodule

// ===== design/kpsdr_scan.sv =====
// ----------------------------------------------------------------------------
// kpsdr_scan
// First pressed key in row-major order, mapped through the code table.
// ----------------------------------------------------------------------------
module kpsdr_scan
    import kpsdr_pkg::*;
(
    input  logic [MATRIX_W-1:0] i_matrix,
    input  t_table              i_table,
    output logic [CODE_W-1:0]   o_code
);

    logic                 found;
    logic [KEY_IDX_W-1:0] idx;

    // walk down so the lowest pressed key wins
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int k = SCAN_KEYS - 1; k >= 0; k--) begin
            if (!i_matrix[k]) begin
                found = 1'b1;
                idx   = KEY_IDX_W'(k);
            end
        end
    end

    assign o_code = found ? i_table[idx*CODE_W +: CODE_W] : '0;

endmodule

// ===== design/kpsdr_fsm.sv =====
// ----------------------------------------------------------------------------
// kpsdr_fsm
// Debounce / press / first-delay / auto-repeat state machine and tick timer.
// ----------------------------------------------------------------------------
module kpsdr_fsm
    import kpsdr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_kind,
    input  logic [CODE_W-1:0] i_code,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    logic [2:0]            r_phase, n_phase;
    logic [CODE_W-1:0]     r_held_code, n_held_code;
    logic [TIMER_BITS-1:0] r_tick_count, n_tick_count;
    logic                  r_timer_running, n_timer_running;

    logic [CMP_W-1:0] cnt_ext;
    logic             same;
    logic [CODE_W-1:0] report;
    logic             rep;

    assign cnt_ext = CMP_W'(r_tick_count);
    assign same    = (i_code == r_held_code);

    always_comb begin
        n_phase         = r_phase;
        n_held_code     = r_held_code;
        n_tick_count    = r_tick_count;
        n_timer_running = r_timer_running;
        report          = '0;
        rep             = 1'b0;
        if (i_kind == KIND_TICK) begin
            if (r_timer_running) begin
                n_tick_count = r_tick_count + 1'b1;
            end
        end else begin
            case (r_phase)
                PH_DEBOUNCE: begin
                    if (cnt_ext >= CMP_W'(i_cfg.debounce_ticks)) begin
                        n_phase = PH_PRESS;
                    end
                end
                PH_PRESS: begin
                    if (same) begin
                        n_tick_count    = '0;
                        n_timer_running = 1'b1;
                        n_phase         = PH_FIRST;
                        report          = i_code;
                    end else begin
                        n_phase         = PH_IDLE;
                        n_held_code     = '0;
                        n_tick_count    = '0;
                        n_timer_running = 1'b0;
                    end
                end
                PH_FIRST, PH_REPEAT: begin
                    if (same) begin
                        if ((r_phase == PH_FIRST &&
                             cnt_ext >= CMP_W'(i_cfg.first_delay_ticks)) ||
                            (r_phase == PH_REPEAT &&
                             cnt_ext >= CMP_W'(i_cfg.repeat_ticks))) begin
                            n_tick_count    = '0;
                            n_timer_running = 1'b1;
                            n_phase         = PH_REPEAT;
                            report          = i_code;
                            rep             = 1'b1;
                        end
                    end else begin
                        n_phase         = PH_IDLE;
                        n_held_code     = '0;
                        n_tick_count    = '0;
                        n_timer_running = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_code != '0) begin
                        n_held_code     = i_code;
                        n_tick_count    = '0;
                        n_timer_running = 1'b1;
                        n_phase         = PH_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_held_code     <= '0;
            r_tick_count    <= '0;
            r_timer_running <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_held_code     <= n_held_code;
            r_tick_count    <= n_tick_count;
            r_timer_running <= n_timer_running;
        end
    end

    assign o_result.key_code  = report;
    assign o_result.is_repeat = rep && (report != '0);

endmodule

// ===== design/kpsdr_chk.sv =====
// ----------------------------------------------------------------------------
// kpsdr_chk
// Port-level checks for the keypad qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module kpsdr_chk
    import kpsdr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [CODE_W-1:0]   o_m_axis_tdata,
    input logic [0:0]          o_m_axis_tuser
);

    // held beat stays put under backpressure
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // repeat flag only rides on a real key code
    a_rep_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata != '0)
        else $error("repeat flag with zero key code");

    // nothing pending right out of reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not empty after reset");

    // an output beat never appears without an accepted input beat
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && !(i_s_axis_tvalid && o_s_axis_tready) &&
        $past(!(i_s_axis_tvalid && o_s_axis_tready)) |=> !o_m_axis_tvalid)
        else $error("output beat without an accepted input beat");

endmodule

bind keypad_scan_debounce_repeat kpsdr_chk u_kpsdr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== bench/keypad_scan_debounce_repeat_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_repeat_check
// Watches the stream and config ports, predicts each scan report and compares.
// ----------------------------------------------------------------------------
// Every accepted slave beat is run through a local copy of the keypad state
// machine (timer, debounce, press, first delay, repeat) using the register
// values seen on the config port. Each scan queues one expected report; every
// master beat is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_repeat_check
    import kpsdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [MATRIX_W-1:0]   i_s_tdata,
    input  logic [0:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [CODE_W-1:0]     i_m_tdata,
    input  logic [0:0]            i_m_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_result                report_q[$];

    logic [TABLE_W-1:0]     tab_lo;
    logic [TABLE_W-1:0]     tab_hi;
    logic [CFG_W-1:0]       deb_lim;
    logic [CFG_W-1:0]       first_lim;
    logic [CFG_W-1:0]       rep_lim;

    logic [2:0]             phase;
    logic [CODE_W-1:0]      held_code;
    logic [TIMER_BITS-1:0]  ticks;
    logic                   running;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_result           want;
        t_result           got;
        logic [CODE_W-1:0] code;
        logic              found;
        if (!i_rst_n) begin
            tab_lo    = '0;
            tab_hi    = '0;
            deb_lim   = DEBOUNCE_RST;
            first_lim = FIRST_RST;
            rep_lim   = REPEAT_RST;
            phase     = PH_IDLE;
            held_code = '0;
            ticks     = '0;
            running   = 1'b0;
            report_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TABLE_LOW:  tab_lo    = i_cfg_data;
                    REG_TABLE_HIGH: tab_hi    = i_cfg_data;
                    REG_DEBOUNCE:   deb_lim   = i_cfg_data[CFG_W-1:0];
                    REG_FIRST:      first_lim = i_cfg_data[CFG_W-1:0];
                    REG_REPEAT:     rep_lim   = i_cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end

            // results first, so a report leaving at this edge never meets
            // the expectation of a scan entering at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.key_code  = i_m_tdata;
                got.is_repeat = i_m_tuser[0];
                if (report_q.size() == 0) begin
                    $display("%0t: report beat with none expected, actual code %02h repeat %0b",
                             $time, got.key_code, got.is_repeat);
                    o_fail_count++;
                end else begin
                    want = report_q.pop_front();
                    if (got.key_code !== want.key_code) begin
                        $display("%0t: key_code expected %02h actual %02h",
                                 $time, want.key_code, got.key_code);
                    end
                    if (got.is_repeat !== want.is_repeat) begin
                        $display("%0t: is_repeat expected %0b actual %0b",
                                 $time, want.is_repeat, got.is_repeat);
                    end
                    if (got !== want)
                        o_fail_count++;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == KIND_TICK) begin
                    if (running)
                        ticks = ticks + 1'b1;
                end else begin
                    code  = '0;
                    found = 1'b0;
                    for (int k = 0; k < SCAN_KEYS; k++) begin
                        if (!found && !i_s_tdata[k]) begin
                            found = 1'b1;
                            code  = (k < 8) ? tab_lo[k*8 +: 8] : tab_hi[(k-8)*8 +: 8];
                        end
                    end
                    want = '0;
                    case (phase)
                        PH_DEBOUNCE: begin
                            if (ticks >= deb_lim)
                                phase = PH_PRESS;
                        end
                        PH_PRESS, PH_FIRST, PH_REPEAT: begin
                            if (code != held_code) begin
                                phase     = PH_IDLE;
                                held_code = '0;
                                ticks     = '0;
                                running   = 1'b0;
                            end else if (phase == PH_PRESS) begin
                                ticks         = '0;
                                running       = 1'b1;
                                phase         = PH_FIRST;
                                want.key_code = code;
                            end else if (ticks >= ((phase == PH_FIRST) ? first_lim : rep_lim))
                            begin
                                ticks          = '0;
                                running        = 1'b1;
                                phase          = PH_REPEAT;
                                want.key_code  = code;
                                want.is_repeat = 1'b1;
                            end
                        end
                        default: begin
                            phase = PH_IDLE;
                            if (code != '0) begin
                                held_code = code;
                                ticks     = '0;
                                running   = 1'b1;
                                phase     = PH_DEBOUNCE;
                            end
                        end
                    endcase
                    if (want.key_code == '0)
                        want.is_repeat = 1'b0;
                    report_q.push_back(want);
                end
            end
        end
        o_pending = report_q.size();
    end

endmodule

// ===== bench/keypad_scan_debounce_repeat_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_repeat_test
// Stimulus and verdict for the keypad scan/debounce/repeat block.
// ----------------------------------------------------------------------------
// Directed scans and ticks walk the state machine through debounce, press,
// first delay, repeat and release.
// Random phases follow under several register settings, mostly key press
// episodes with random content plus noise beats. The sender idles in bursts,
// the receiver stalls on its own, once for a long stretch. The checker module
// predicts and compares; this module drives and reports the outcome.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_repeat_test;
    import kpsdr_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BEATS  = 170;
    localparam int LONG_HOLD    = 400;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [MATRIX_W-1:0]   i_s_axis_tdata  = '1;
    logic [0:0]            i_s_axis_tuser  = KIND_TICK;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [CODE_W-1:0]     o_m_axis_tdata;
    logic [0:0]            o_m_axis_tuser;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    int                    fail_count;
    int                    report_pending;
    int                    beats_sent      = 0;
    int                    burst_left      = 0;
    int                    idle_cycles     = 0;
    logic                  long_stall_req  = 1'b0;
    logic [CFG_W-1:0]      deb_cfg         = DEBOUNCE_RST;
    logic [CFG_W-1:0]      first_cfg       = FIRST_RST;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    keypad_scan_debounce_repeat dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    keypad_scan_debounce_repeat_check check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (report_pending)
    );

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : sink
        int hold_left;
        int stretch_left;
        int ready_pct;
        hold_left    = 0;
        stretch_left = 0;
        ready_pct    = 100;
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold_left      = LONG_HOLD;
            end
            if (stretch_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                stretch_left = $urandom_range(10, 80);
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    task automatic send_beat(input logic kind, input logic [MATRIX_W-1:0] matrix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= matrix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(KIND_TICK, MATRIX_W'($urandom));
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (report_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_cfg(input t_table tab, input logic [CFG_W-1:0] deb,
                               input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] rep);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_TABLE_LOW;
        i_cfg_data <= tab[TABLE_W-1:0];
        @(posedge i_clk);
        i_cfg_addr <= REG_TABLE_HIGH;
        i_cfg_data <= tab[2*TABLE_W-1:TABLE_W];
        @(posedge i_clk);
        // upper data bits are don't-care for the 16-bit thresholds
        i_cfg_addr <= REG_DEBOUNCE;
        i_cfg_data <= {32'($urandom), 16'($urandom), deb};
        @(posedge i_clk);
        i_cfg_addr <= REG_FIRST;
        i_cfg_data <= {32'($urandom), 16'($urandom), first};
        @(posedge i_clk);
        i_cfg_addr <= REG_REPEAT;
        i_cfg_data <= {32'($urandom), 16'($urandom), rep};
        @(posedge i_clk);
        // unmapped index, must be ignored
        i_cfg_addr <= CFG_ADDR_W'($urandom_range(REG_REPEAT + 1, (1 << CFG_ADDR_W) - 1));
        i_cfg_data <= {32'($urandom), 32'($urandom)};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        deb_cfg    = deb;
        first_cfg  = first;
    endtask

    function automatic t_table random_table(input bit allow_zero);
        t_table      tab;
        logic [7:0]  code;
        tab = '0;
        for (int k = 0; k < 2 * TABLE_W / 8; k++) begin
            code = 8'($urandom);
            case ($urandom_range(0, 9))
                0:       if (allow_zero) code = '0;
                1:       code = tab[7:0];
                default: ;
            endcase
            if (!allow_zero)
                code[0] = 1'b1;
            tab[k*8 +: 8] = code;
        end
        return tab;
    endfunction

    // key held down, possibly with later keys in scan order pressed as well
    function automatic logic [MATRIX_W-1:0] pressed_matrix(input int key);
        logic [MATRIX_W-1:0] later;
        later = MATRIX_W'($urandom) & (16'hFFFF << (key + 1));
        return ~(later | (16'd1 << key));
    endfunction

    function automatic int tick_span(input logic [CFG_W-1:0] lim);
        return (lim > 6) ? 6 : int'(lim);
    endfunction

    task automatic press_episode();
        int key;
        key = $urandom_range(0, SCAN_KEYS - 1);
        send_beat(KIND_SCAN, pressed_matrix(key));
        send_ticks($urandom_range(0, tick_span(deb_cfg) + 2));
        send_beat(KIND_SCAN, ($urandom_range(0, 4) == 0) ? MATRIX_W'($urandom)
                                                         : pressed_matrix(key));
        repeat ($urandom_range(1, 6)) begin
            send_beat(KIND_SCAN, pressed_matrix(key));
            send_ticks($urandom_range(0, tick_span(first_cfg) + 1));
        end
        case ($urandom_range(0, 2))
            0:       send_beat(KIND_SCAN, '1);
            1:       send_beat(KIND_SCAN, pressed_matrix($urandom_range(0, SCAN_KEYS - 1)));
            default: ;
        endcase
    endtask

    task automatic noise_beat();
        send_beat(($urandom_range(0, 1) == 0) ? KIND_TICK : KIND_SCAN, MATRIX_W'($urandom));
    endtask

    initial begin : stimulus
        int     goal;
        t_table tab;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset table is all zero: every key reads as none
        send_beat(KIND_SCAN, 16'h0000);
        send_beat(KIND_SCAN, 16'hFFFF);
        send_beat(KIND_TICK, 16'hA5A5);

        // key 2 maps to zero, key 15 to 0xFF
        program_cfg({64'hFF0F_0E0D_0C0B_0A09, 64'h0807_0605_0400_0201}, 2, 3, 1);
        send_beat(KIND_SCAN, 16'h7FFF);
        send_beat(KIND_SCAN, 16'hFFFE);         // ignored while debouncing
        send_ticks(2);
        send_beat(KIND_SCAN, 16'hFFFF);         // debounce done, goes to press
        send_beat(KIND_SCAN, 16'h7FFF);         // first report
        send_ticks(3);
        send_beat(KIND_SCAN, 16'h7FFF);         // first repeat
        send_ticks(1);
        send_beat(KIND_SCAN, 16'h7FFF);
        send_beat(KIND_SCAN, 16'h7FFF);         // too early, no report
        send_beat(KIND_SCAN, 16'hFFFF);         // release
        send_beat(KIND_SCAN, 16'hFFFB);         // zero-mapped key
        send_beat(KIND_SCAN, 16'hFFF3);         // zero-mapped key wins scan order
        send_beat(KIND_SCAN, 16'hFFEF);
        send_ticks(2);
        send_beat(KIND_SCAN, 16'hFFEF);
        send_beat(KIND_SCAN, 16'hFFDF);         // other code drops the key
        send_beat(KIND_SCAN, 16'h0000);

        for (int ph = 0; ph < 6; ph++) begin
            tab = random_table(1'b1);
            case (ph)
                0:       program_cfg(tab, '0, '0, '0);
                5:       program_cfg(tab, '1, '1, '1);
                default: program_cfg(tab, CFG_W'($urandom_range(0, 4)),
                                     CFG_W'($urandom_range(0, 8)),
                                     CFG_W'($urandom_range(0, 4)));
            endcase
            goal = beats_sent + PHASE_BEATS;
            if (ph == 2) begin
                long_stall_req = 1'b1;
                burst_left     = 60;
                repeat (40) send_beat(KIND_SCAN, MATRIX_W'($urandom));
            end
            while (beats_sent < goal) begin
                if ($urandom_range(0, 4) == 0)
                    noise_beat();
                else
                    press_episode();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
